[hdl/ufs_pkg.sv]
// ufs_pkg: shared types, constants and helper functions of the url field splitter
// no dependencies; used by every file of the block

package ufs_pkg;

  localparam int unsigned MAX_URL_LEN = 1024;
  localparam int unsigned POS_W       = $clog2(MAX_URL_LEN + 1);
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned OFF_W       = 10;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned CHAR_W      = 8;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic REG_DEFAULT_PORT = 1'b0;
  localparam logic REG_SECURE_PORT  = 1'b1;

  localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd80;
  localparam logic [PORT_W-1:0] SECURE_PORT_RST  = 16'd443;
  localparam logic [PORT_W-1:0] PORT_MAX         = 16'hFFFF;

  localparam logic [1:0] PH_SCHEME = 2'd0;
  localparam logic [1:0] PH_AUTH   = 2'd1;
  localparam logic [1:0] PH_PATH   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SEP   = 2'd1;
  localparam logic [1:0] ST_BAD_CRED = 2'd2;
  localparam logic [1:0] ST_LONG     = 2'd3;

  localparam logic [1:0] TAIL_NONE   = 2'd0;
  localparam logic [1:0] TAIL_PARAMS = 2'd1;
  localparam logic [1:0] TAIL_QUERY  = 2'd2;

  localparam logic [15:0] RECENT_SEP = 16'h3A2F;
  localparam int unsigned HTTPS_LEN  = 5;
  localparam int unsigned WSS_LEN    = 3;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_COLON,
    CLS_SLASH,
    CLS_AT,
    CLS_SEMI,
    CLS_QUEST,
    CLS_DOT
  } ufs_cls_e;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    ufs_cls_e          cls;
    logic              last;
  } ufs_ent_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PORT_W-1:0] port_number;
    logic [LEN_W-1:0]  scheme_len;
    logic [LEN_W-1:0]  user_len;
    logic [LEN_W-1:0]  pass_len;
    logic [OFF_W-1:0]  host_start;
    logic [LEN_W-1:0]  host_len;
    logic [OFF_W-1:0]  path_start;
    logic [LEN_W-1:0]  path_len;
    logic [1:0]        tail_kind;
    logic [OFF_W-1:0]  tail_start;
    logic              host_is_ipv4;
  } ufs_res_t;

  function automatic logic [CHAR_W-1:0] https_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h70;
      default: ch = 8'h73;
    endcase
    return ch;
  endfunction

  function automatic logic [CHAR_W-1:0] wss_char(input logic [1:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      2'd0:    ch = 8'h77;
      default: ch = 8'h73;
    endcase
    return ch;
  endfunction

endpackage

[hdl/ufs_in_if.sv]
// ufs_in_if: byte input channel, valid/ready handshake
// depends on ufs_pkg

interface ufs_in_if;
  logic                       valid;
  logic                       ready;
  logic [ufs_pkg::CHAR_W-1:0] char_in;
  logic                       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

[hdl/ufs_out_if.sv]
// ufs_out_if: result output channel, valid/ready handshake
// depends on ufs_pkg

interface ufs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [ufs_pkg::PORT_W-1:0] port_number;
  logic [ufs_pkg::LEN_W-1:0]  scheme_len;
  logic [ufs_pkg::LEN_W-1:0]  user_len;
  logic [ufs_pkg::LEN_W-1:0]  pass_len;
  logic [ufs_pkg::OFF_W-1:0]  host_start;
  logic [ufs_pkg::LEN_W-1:0]  host_len;
  logic [ufs_pkg::OFF_W-1:0]  path_start;
  logic [ufs_pkg::LEN_W-1:0]  path_len;
  logic [1:0]                 tail_kind;
  logic [ufs_pkg::OFF_W-1:0]  tail_start;
  logic                       host_is_ipv4;

  modport source (output valid, output status, output port_number, output scheme_len,
                  output user_len, output pass_len, output host_start, output host_len,
                  output path_start, output path_len, output tail_kind, output tail_start,
                  output host_is_ipv4, input ready);
  modport sink (input valid, input status, input port_number, input scheme_len,
                input user_len, input pass_len, input host_start, input host_len,
                input path_start, input path_len, input tail_kind, input tail_start,
                input host_is_ipv4, output ready);
endinterface

[hdl/url_field_splitter_core.sv]
// url_field_splitter_core: top level of the streaming url field splitter
// depends on ufs_pkg, ufs_in_if, ufs_out_if, ufs_cfg, ufs_front and ufs_back

// The block takes one url byte per cycle on in_ch while in_ch.ready is high and, for the
// byte flagged last_char, delivers one result on out_ch giving status, port number and the
// offsets and lengths of scheme, credentials, host, path and params or query, plus a dotted
// quad flag for the host. The back stage updates the parser state per byte; the last
// byte passes through the front queue and the result register, and the next url may
// stream in while that result waits on out_ch. Bytes beyond 1024 in one url are dropped
// and report status 3. The port registers (default_port at 0x0, secure_port at 0x4)
// must be written over apb while no url is in flight; the block does not enforce it.

module url_field_splitter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ufs_in_if.sink                         in_ch,
  ufs_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                       ent_valid;
  logic                       pop;
  ufs_pkg::ufs_ent_t          ent;
  logic [ufs_pkg::PORT_W-1:0] default_port;
  logic [ufs_pkg::PORT_W-1:0] secure_port;
  ufs_pkg::ufs_res_t          res;

  ufs_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready),
    .default_port_o (default_port),
    .secure_port_o  (secure_port)
  );

  ufs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .pop_i       (pop),
    .ent_valid_o (ent_valid),
    .ent_o       (ent)
  );

  ufs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ent_valid_i    (ent_valid),
    .ent_i          (ent),
    .pop_o          (pop),
    .default_port_i (default_port),
    .secure_port_i  (secure_port),
    .res_valid_o    (out_ch.valid),
    .res_ready_i    (out_ch.ready),
    .res_o          (res)
  );

  assign out_ch.status       = res.status;
  assign out_ch.port_number  = res.port_number;
  assign out_ch.scheme_len   = res.scheme_len;
  assign out_ch.user_len     = res.user_len;
  assign out_ch.pass_len     = res.pass_len;
  assign out_ch.host_start   = res.host_start;
  assign out_ch.host_len     = res.host_len;
  assign out_ch.path_start   = res.path_start;
  assign out_ch.path_len     = res.path_len;
  assign out_ch.tail_kind    = res.tail_kind;
  assign out_ch.tail_start   = res.tail_start;
  assign out_ch.host_is_ipv4 = res.host_is_ipv4;

endmodule

[hdl/ufs_cfg.sv]
// ufs_cfg: apb register file holding the default and secure port numbers
// depends on ufs_pkg

module ufs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [ufs_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [ufs_pkg::APB_DATA_W-1:0] pwdata_i,
  output logic [ufs_pkg::APB_DATA_W-1:0] prdata_o,
  output logic                           pready_o,
  output logic [ufs_pkg::PORT_W-1:0]     default_port_o,
  output logic [ufs_pkg::PORT_W-1:0]     secure_port_o
);

  logic [ufs_pkg::PORT_W-1:0] default_port_q, default_port_d;
  logic [ufs_pkg::PORT_W-1:0] secure_port_q, secure_port_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_sel = paddr_i[2];

  always_comb begin
    default_port_d = default_port_q;
    secure_port_d  = secure_port_q;
    if (wr_en) begin
      case (reg_sel)
        ufs_pkg::REG_DEFAULT_PORT: default_port_d = pwdata_i[ufs_pkg::PORT_W-1:0];
        ufs_pkg::REG_SECURE_PORT:  secure_port_d  = pwdata_i[ufs_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= ufs_pkg::DEFAULT_PORT_RST;
      secure_port_q  <= ufs_pkg::SECURE_PORT_RST;
    end else begin
      default_port_q <= default_port_d;
      secure_port_q  <= secure_port_d;
    end
  end

  always_comb begin
    case (reg_sel)
      ufs_pkg::REG_DEFAULT_PORT: prdata_o = ufs_pkg::APB_DATA_W'(default_port_q);
      ufs_pkg::REG_SECURE_PORT:  prdata_o = ufs_pkg::APB_DATA_W'(secure_port_q);
      default:                   prdata_o = '0;
    endcase
  end

  assign pready_o       = 1'b1;
  assign default_port_o = default_port_q;
  assign secure_port_o  = secure_port_q;

endmodule

[hdl/ufs_front.sv]
// ufs_front: accepts url bytes, classifies them and holds them in a short queue
// depends on ufs_pkg and ufs_in_if

module ufs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ufs_in_if.sink            in_ch,
  input  logic              pop_i,
  output logic              ent_valid_o,
  output ufs_pkg::ufs_ent_t ent_o
);

  ufs_pkg::ufs_ent_t          ent_q [ufs_pkg::QDEPTH];
  logic [ufs_pkg::QPTR_W-1:0] wptr_q, wptr_d;
  logic [ufs_pkg::QPTR_W-1:0] rptr_q, rptr_d;
  logic [ufs_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       push;
  logic                       pop;
  ufs_pkg::ufs_ent_t          new_ent;

  function automatic ufs_pkg::ufs_cls_e classify(input logic [ufs_pkg::CHAR_W-1:0] c);
    ufs_pkg::ufs_cls_e k;
    if (c >= 8'h30 && c <= 8'h39) k = ufs_pkg::CLS_DIGIT;
    else begin
      case (c)
        8'h3A:   k = ufs_pkg::CLS_COLON;
        8'h2F:   k = ufs_pkg::CLS_SLASH;
        8'h40:   k = ufs_pkg::CLS_AT;
        8'h3B:   k = ufs_pkg::CLS_SEMI;
        8'h3F:   k = ufs_pkg::CLS_QUEST;
        8'h2E:   k = ufs_pkg::CLS_DOT;
        default: k = ufs_pkg::CLS_OTHER;
      endcase
    end
    return k;
  endfunction

  assign in_ch.ready = (cnt_q != ufs_pkg::QCNT_W'(ufs_pkg::QDEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = pop_i & ent_valid_o;

  assign new_ent.chr  = in_ch.char_in;
  assign new_ent.cls  = classify(in_ch.char_in);
  assign new_ent.last = in_ch.last_char;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) wptr_d = wptr_q + ufs_pkg::QPTR_W'(1);
    if (pop) rptr_d = rptr_q + ufs_pkg::QPTR_W'(1);
    if (push && !pop) cnt_d = cnt_q + ufs_pkg::QCNT_W'(1);
    else if (pop && !push) cnt_d = cnt_q - ufs_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= new_ent;
  end

  assign ent_valid_o = (cnt_q != '0);
  assign ent_o       = ent_q[rptr_q];

endmodule

[hdl/ufs_back.sv]
// ufs_back: per-byte parser state, result assembly and output register
// depends on ufs_pkg

module ufs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ent_valid_i,
  input  ufs_pkg::ufs_ent_t          ent_i,
  output logic                       pop_o,
  input  logic [ufs_pkg::PORT_W-1:0] default_port_i,
  input  logic [ufs_pkg::PORT_W-1:0] secure_port_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ufs_pkg::ufs_res_t          res_o
);

  localparam int unsigned PW = ufs_pkg::POS_W;

  typedef struct packed {
    logic [1:0]                 phase;
    logic [15:0]                recent;
    logic [PW-1:0]              pos;
    logic                       too_long;
    logic [ufs_pkg::PORT_W-1:0] port0;
    logic [ufs_pkg::PORT_W-1:0] port1;
    logic                       run1;
    logic                       run2;
    logic                       c1;
    logic                       at;
    logic                       c2;
    logic                       semi;
    logic                       quest;
    logic [PW-1:0]              o_send;
    logic [PW-1:0]              o_auth;
    logic [PW-1:0]              o_c1;
    logic [PW-1:0]              o_at;
    logic [PW-1:0]              o_c2;
    logic [PW-1:0]              o_slash;
    logic [PW-1:0]              o_semi;
    logic [PW-1:0]              o_quest;
    logic [1:0]                 smatch;
    logic [4:0]                 ck0;
    logic [4:0]                 ck1;
  } ufs_st_t;

  ufs_st_t                    st_q, st_d, nx, st_clear;
  ufs_pkg::ufs_res_t          res_q, res_d, res;
  logic                       res_valid_q, res_valid_d;
  logic                       pop;
  logic [PW-1:0]              cur_pos;
  logic [ufs_pkg::CHAR_W-1:0] cur_chr;
  logic                       is_digit;
  logic                       sec;
  logic [ufs_pkg::PORT_W-1:0] dflt;
  logic [PW-1:0]              host_end;
  logic [PW-1:0]              pend;
  logic [PW-1:0]              pend_p1;
  logic [PW-1:0]              at_p1;

  function automatic logic [4:0] ck_feed(input logic [4:0] st, input ufs_pkg::ufs_cls_e cls);
    logic [1:0] g;
    logic [1:0] k;
    logic       bad;
    g   = st[1:0];
    k   = st[3:2];
    bad = st[4];
    if (cls == ufs_pkg::CLS_DIGIT) begin
      if (k == 2'd3) bad = 1'b1;
      else k = k + 2'd1;
    end else if (cls == ufs_pkg::CLS_DOT) begin
      if (k == 2'd0 || g == 2'd3) bad = 1'b1;
      else begin
        g = g + 2'd1;
        k = 2'd0;
      end
    end else begin
      bad = 1'b1;
    end
    return {bad, k, g};
  endfunction

  function automatic logic ck_final(input logic [4:0] st);
    return !st[4] && (st[1:0] == 2'd3) && (st[3:2] != 2'd0);
  endfunction

  function automatic logic [ufs_pkg::PORT_W-1:0] port_add(
    input logic [ufs_pkg::PORT_W-1:0] acc, input logic [3:0] dig);
    logic [ufs_pkg::PORT_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (ufs_pkg::PORT_W+4)'(dig);
    return (v > (ufs_pkg::PORT_W+4)'(ufs_pkg::PORT_MAX)) ? ufs_pkg::PORT_MAX
                                                         : v[ufs_pkg::PORT_W-1:0];
  endfunction

  always_comb begin
    st_clear        = '0;
    st_clear.phase  = ufs_pkg::PH_SCHEME;
    st_clear.smatch = 2'b11;
  end

  assign pop      = ent_valid_i & (!ent_i.last | !res_valid_q | res_ready_i);
  assign pop_o    = pop;
  assign cur_pos  = st_q.pos;
  assign cur_chr  = ent_i.chr;
  assign is_digit = (ent_i.cls == ufs_pkg::CLS_DIGIT);

  // per-byte update
  always_comb begin
    nx = st_q;
    if (pop && !st_q.too_long) begin
      if (cur_pos == PW'(ufs_pkg::MAX_URL_LEN)) begin
        nx.too_long = 1'b1;
      end else begin
        case (st_q.phase)
          ufs_pkg::PH_SCHEME: begin
            if (cur_pos < PW'(ufs_pkg::HTTPS_LEN) &&
                cur_chr != ufs_pkg::https_char(cur_pos[2:0])) nx.smatch[0] = 1'b0;
            if (cur_pos < PW'(ufs_pkg::WSS_LEN) &&
                cur_chr != ufs_pkg::wss_char(cur_pos[1:0])) nx.smatch[1] = 1'b0;
            if (ent_i.cls == ufs_pkg::CLS_SLASH && st_q.recent == ufs_pkg::RECENT_SEP) begin
              nx.o_send = cur_pos - PW'(2);
              nx.o_auth = cur_pos + PW'(1);
              nx.phase  = ufs_pkg::PH_AUTH;
            end
          end
          ufs_pkg::PH_AUTH: begin
            if (ent_i.cls == ufs_pkg::CLS_SLASH) begin
              nx.o_slash = cur_pos;
              nx.phase   = ufs_pkg::PH_PATH;
            end else begin
              if (st_q.run1) begin
                if (is_digit) nx.port0 = port_add(st_q.port0, cur_chr[3:0]);
                else nx.run1 = 1'b0;
              end
              if (st_q.run2) begin
                if (is_digit) nx.port1 = port_add(st_q.port1, cur_chr[3:0]);
                else nx.run2 = 1'b0;
              end
              if (!st_q.c1 && ent_i.cls != ufs_pkg::CLS_COLON)
                nx.ck0 = ck_feed(st_q.ck0, ent_i.cls);
              if (st_q.at && !st_q.c2 && ent_i.cls != ufs_pkg::CLS_COLON)
                nx.ck1 = ck_feed(st_q.ck1, ent_i.cls);
              if (ent_i.cls == ufs_pkg::CLS_AT && !st_q.at) begin
                nx.at   = 1'b1;
                nx.o_at = cur_pos;
              end
              if (ent_i.cls == ufs_pkg::CLS_COLON) begin
                if (!st_q.c1) begin
                  nx.c1    = 1'b1;
                  nx.run1  = 1'b1;
                  nx.o_c1  = cur_pos;
                  nx.port0 = '0;
                end
                if (st_q.at && !st_q.c2) begin
                  nx.c2    = 1'b1;
                  nx.run2  = 1'b1;
                  nx.o_c2  = cur_pos;
                  nx.port1 = '0;
                end
              end
            end
          end
          default: begin
            if (ent_i.cls == ufs_pkg::CLS_SEMI && !st_q.semi) begin
              nx.semi   = 1'b1;
              nx.o_semi = cur_pos;
            end
            if (ent_i.cls == ufs_pkg::CLS_QUEST && !st_q.quest) begin
              nx.quest   = 1'b1;
              nx.o_quest = cur_pos;
            end
          end
        endcase
        nx.recent = {st_q.recent[7:0], cur_chr};
        nx.pos    = cur_pos + PW'(1);
      end
    end
  end

  // result assembly from the updated state
  assign at_p1 = nx.o_at + PW'(1);
  assign sec   = (nx.o_send == PW'(ufs_pkg::HTTPS_LEN) && nx.smatch[0]) ||
                 (nx.o_send == PW'(ufs_pkg::WSS_LEN) && nx.smatch[1]);
  assign dflt  = sec ? secure_port_i : default_port_i;

  always_comb begin
    res      = '0;
    host_end = '0;
    pend     = nx.pos;
    if (nx.too_long) begin
      res.status = ufs_pkg::ST_LONG;
    end else if (nx.phase == ufs_pkg::PH_SCHEME) begin
      res.status = ufs_pkg::ST_NO_SEP;
    end else if (nx.phase == ufs_pkg::PH_PATH && nx.at && (!nx.c1 || nx.o_c1 > nx.o_at)) begin
      res.status = ufs_pkg::ST_BAD_CRED;
    end else begin
      res.scheme_len = nx.o_send;
      res.host_start = nx.o_auth[ufs_pkg::OFF_W-1:0];
      if (nx.phase == ufs_pkg::PH_AUTH || !nx.at) begin
        if (nx.c1) host_end = nx.o_c1;
        else if (nx.phase == ufs_pkg::PH_AUTH) host_end = nx.pos;
        else host_end = nx.o_slash;
        res.port_number  = nx.c1 ? nx.port0 : dflt;
        res.host_len     = host_end - nx.o_auth;
        res.host_is_ipv4 = ck_final(nx.ck0);
      end else begin
        host_end         = nx.c2 ? nx.o_c2 : nx.o_slash;
        res.user_len     = nx.o_c1 - nx.o_auth;
        res.pass_len     = nx.o_at - nx.o_c1 - PW'(1);
        res.host_start   = at_p1[ufs_pkg::OFF_W-1:0];
        res.port_number  = nx.c2 ? nx.port1 : dflt;
        res.host_len     = host_end - at_p1;
        res.host_is_ipv4 = ck_final(nx.ck1);
      end
      if (nx.phase == ufs_pkg::PH_PATH) begin
        if (nx.semi) begin
          pend          = nx.o_semi;
          res.tail_kind = ufs_pkg::TAIL_PARAMS;
        end else if (nx.quest) begin
          pend          = nx.o_quest;
          res.tail_kind = ufs_pkg::TAIL_QUERY;
        end
        res.path_start = nx.o_slash[ufs_pkg::OFF_W-1:0];
        res.path_len   = pend - nx.o_slash;
        res.tail_start = (res.tail_kind != ufs_pkg::TAIL_NONE) ?
                         pend_p1[ufs_pkg::OFF_W-1:0] : '0;
      end
    end
  end

  assign pend_p1 = pend + PW'(1);

  always_comb begin
    st_d        = (pop && ent_i.last) ? st_clear : nx;
    res_d       = res_q;
    res_valid_d = res_valid_q & !res_ready_i;
    if (pop && ent_i.last) begin
      res_d       = res;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= st_clear;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hdl/ufs_checker.sv]
// ufs_checker: port-level assertions on the result channel of the splitter
// depends on ufs_pkg; bound to url_field_splitter_core

module ufs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 status_i,
  input logic [ufs_pkg::PORT_W-1:0] port_number_i,
  input logic [ufs_pkg::LEN_W-1:0]  host_len_i,
  input logic [1:0]                 tail_kind_i,
  input logic [ufs_pkg::OFF_W-1:0]  tail_start_i
);

  // stalled result holds until transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
                                    $stable(port_number_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ufs_pkg::ST_OK |->
      port_number_i == '0 && host_len_i == '0 && tail_kind_i == ufs_pkg::TAIL_NONE)
    else $error("error result carries field data");

  a_tail_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tail_kind_i == ufs_pkg::TAIL_NONE || tail_kind_i == ufs_pkg::TAIL_PARAMS ||
                    tail_kind_i == ufs_pkg::TAIL_QUERY)
    else $error("reserved tail kind");

  a_no_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tail_kind_i == ufs_pkg::TAIL_NONE |-> tail_start_i == '0)
    else $error("tail offset without tail");

endmodule

bind url_field_splitter_core ufs_checker u_ufs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .status_i      (out_ch.status),
  .port_number_i (out_ch.port_number),
  .host_len_i    (out_ch.host_len),
  .tail_kind_i   (out_ch.tail_kind),
  .tail_start_i  (out_ch.tail_start)
);
